[rtl/blecs_pkg.sv]
// shared types and constants of the connection event scheduler
package blecs_pkg;

   // command codes of the request channel
   typedef enum logic [1:0] {
      CMD_CONNECT = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RX_TIME = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   // timing constants in timer ticks
   parameter logic [31:0] TICKS_PER_UNIT = 32'd5000;
   parameter logic [31:0] SKIP_LIMIT     = 32'd60000;
   parameter logic [31:0] START_LEAD     = 32'd4000;
   parameter logic [31:0] WAKE_LEAD      = 32'd12000;
   parameter logic [16:0] TIMEOUT_LEAD   = 17'd4000;
   parameter logic [15:0] TIMEOUT_MAX    = 16'hFFFF;

   // data channel count
   parameter logic [6:0]  NUM_CHANNELS   = 7'd37;

endpackage

[rtl/ble_connection_event_scheduler.sv]
// connection event scheduler: timing and channel hopping of slave events
//
// Usage: the req_ channel carries one transaction per command: a connection
// request, an anchor timer tick or a receive timestamp report (cmd). A
// connection request and every tick after a connection yield one rsp_
// transaction with the radio start time, receive timeout, wake-up compare
// value, data channel and event number. Reports update state only, and ticks
// that come before a connection are ignored; neither yields a response.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while req_stall is low; the state update
// of each request is a single registered pass (a few 32-bit adds and one
// mod-37 step), and the anchor product interval * (n + 1) is kept as a running
// sum, so no multiplier sits in the loop.
// Reset (synchronous, active high) clears the connection state and drops
// any pending response.
// When the receiver stalls, the response register holds its value and
// req_stall rises, so no further request is taken until it drains.
module ble_connection_event_scheduler
   import blecs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_hop_increment,
   input  logic [11:0] req_interval_units,
   input  logic [11:0] req_window_offset_units,
   input  logic [3:0]  req_window_size_units,
   input  logic [31:0] req_request_time,
   input  logic [31:0] req_rx_time,
   input  logic        req_rx_time_valid,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_issue_command,
   output logic [5:0]  rsp_channel,
   output logic [31:0] rsp_radio_start,
   output logic [15:0] rsp_rx_timeout,
   output logic        rsp_first_event,
   output logic [31:0] rsp_wake_compare,
   output logic [31:0] rsp_event_count
);

   // connection state
   logic        connected_ff, connected_in;
   logic [4:0]  hop_step_ff, hop_step_in;
   logic [23:0] interval_ticks_ff, interval_ticks_in;
   logic [15:0] window_ticks_ff, window_ticks_in;
   logic [31:0] first_anchor_ff, first_anchor_in;
   logic        anchor_known_ff, anchor_known_in;
   logic [31:0] next_anchor_ff, next_anchor_in;
   logic [31:0] event_number_ff, event_number_in;
   logic [5:0]  channel_ff, channel_in;
   logic [31:0] interval_sum_ff, interval_sum_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_channel_ff, rsp_channel_in;
   logic [31:0] rsp_start_ff, rsp_start_in;
   logic [15:0] rsp_timeout_ff, rsp_timeout_in;
   logic        rsp_first_ff, rsp_first_in;
   logic [31:0] rsp_wake_ff, rsp_wake_in;
   logic [31:0] rsp_event_ff, rsp_event_in;

   logic        take;
   logic        emit;
   cmd_type     cmd;
   logic [31:0] offset_ticks;
   logic [31:0] interval_full;
   logic [31:0] window_full;
   logic [31:0] base_anchor;
   logic [31:0] anchor_sel;
   logic [6:0]  hop_sum;
   logic [5:0]  hop_channel;
   logic [16:0] timeout_sum;

   // a request is taken unless a stalled response blocks the output
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign cmd       = cmd_type'(req_cmd);

   // constant scaling of the request fields
   assign offset_ticks  = 32'(req_window_offset_units) * TICKS_PER_UNIT;
   assign interval_full = 32'(req_interval_units) * TICKS_PER_UNIT;
   assign window_full   = 32'(req_window_size_units) * TICKS_PER_UNIT;
   assign base_anchor   = req_request_time + offset_ticks;

   // next state, channel hop and response
   always_comb begin
      connected_in      = connected_ff;
      hop_step_in       = hop_step_ff;
      interval_ticks_in = interval_ticks_ff;
      window_ticks_in   = window_ticks_ff;
      first_anchor_in   = first_anchor_ff;
      anchor_known_in   = anchor_known_ff;
      next_anchor_in    = next_anchor_ff;
      event_number_in   = event_number_ff;
      channel_in        = channel_ff;
      interval_sum_in   = interval_sum_ff;
      emit              = 1'b0;
      rsp_first_in      = 1'b0;
      anchor_sel        = next_anchor_ff;
      hop_sum           = 7'(channel_ff) + 7'(hop_step_ff);

      case (cmd)
         CMD_CONNECT: begin
            hop_step_in       = req_hop_increment;
            interval_ticks_in = interval_full[23:0];
            window_ticks_in   = (window_full > 32'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                                                                 : window_full[15:0];
            event_number_in   = '0;
            // hop below 37, so hop mod 37 is the hop itself
            hop_sum           = 7'(req_hop_increment) + 7'(req_hop_increment);
            if (offset_ticks <= SKIP_LIMIT) begin
               first_anchor_in = base_anchor + 32'(interval_full[23:0]);
            end else begin
               first_anchor_in = base_anchor;
            end
            anchor_known_in   = 1'b0;
            connected_in      = 1'b1;
            interval_sum_in   = 32'(interval_full[23:0]);
            next_anchor_in    = first_anchor_in + 32'(interval_full[23:0]);
            anchor_sel        = first_anchor_in;
            rsp_first_in      = 1'b1;
            emit              = 1'b1;
         end
         CMD_TICK: begin
            if (connected_ff) begin
               event_number_in = event_number_ff + 32'd1;
               interval_sum_in = interval_sum_ff + 32'(interval_ticks_ff);
               next_anchor_in  = first_anchor_ff + interval_sum_in;
               emit            = 1'b1;
            end
         end
         CMD_RX_TIME: begin
            if (!anchor_known_ff && req_rx_time_valid) begin
               anchor_known_in = 1'b1;
               first_anchor_in = req_rx_time;
            end
         end
         default: begin
         end
      endcase

      // one hop step: sum stays below twice the channel count
      hop_channel = (hop_sum >= NUM_CHANNELS) ? 6'(hop_sum - NUM_CHANNELS)
                                              : hop_sum[5:0];
      if (cmd == CMD_CONNECT) begin
         channel_in = (offset_ticks <= SKIP_LIMIT) ? hop_channel
                                                   : 6'(req_hop_increment);
      end else if (cmd == CMD_TICK && connected_ff) begin
         channel_in = hop_channel;
      end

      // response fields from the updated state
      timeout_sum    = 17'(window_ticks_in) + TIMEOUT_LEAD;
      rsp_channel_in = channel_in;
      rsp_start_in   = anchor_sel - START_LEAD;
      rsp_timeout_in = timeout_sum[16] ? TIMEOUT_MAX : timeout_sum[15:0];
      rsp_wake_in    = next_anchor_in - WAKE_LEAD;
      rsp_event_in   = event_number_in;

      // output register handshake
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff      <= 1'b0;
         hop_step_ff       <= '0;
         interval_ticks_ff <= '0;
         window_ticks_ff   <= '0;
         first_anchor_ff   <= '0;
         anchor_known_ff   <= 1'b0;
         next_anchor_ff    <= '0;
         event_number_ff   <= '0;
         channel_ff        <= '0;
         interval_sum_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            connected_ff      <= connected_in;
            hop_step_ff       <= hop_step_in;
            interval_ticks_ff <= interval_ticks_in;
            window_ticks_ff   <= window_ticks_in;
            first_anchor_ff   <= first_anchor_in;
            anchor_known_ff   <= anchor_known_in;
            next_anchor_ff    <= next_anchor_in;
            event_number_ff   <= event_number_in;
            channel_ff        <= channel_in;
            interval_sum_ff   <= interval_sum_in;
         end
      end
      // payload loads only with a new response
      if (take && emit) begin
         rsp_channel_ff <= rsp_channel_in;
         rsp_start_ff   <= rsp_start_in;
         rsp_timeout_ff <= rsp_timeout_in;
         rsp_first_ff   <= rsp_first_in;
         rsp_wake_ff    <= rsp_wake_in;
         rsp_event_ff   <= rsp_event_in;
      end
   end

   // response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_issue_command = 1'b1;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_radio_start   = rsp_start_ff;
   assign rsp_rx_timeout    = rsp_timeout_ff;
   assign rsp_first_event   = rsp_first_ff;
   assign rsp_wake_compare  = rsp_wake_ff;
   assign rsp_event_count   = rsp_event_ff;

endmodule
